// ----- rtl/core/scqp_pkg.sv -----
// shared constants and arithmetic helpers for the sine/cosine pipeline
package scqp_pkg;

    // fraction bits of the reduced angle and of the polynomial datapath
    localparam int RFRAC = 40;
    localparam int PFRAC = 30;

    // 2/pi as unsigned q32
    localparam logic [31:0] TWO_OVER_PI_Q32 = 32'd2734261102;

    // pi/2 as q40, split into high and low halves for two narrow multipliers
    localparam logic [40:0] HALF_PI_Q40 = 41'd1727108826179;
    localparam logic [20:0] HALF_PI_HI  = HALF_PI_Q40[40:20];
    localparam logic [19:0] HALF_PI_LO  = HALF_PI_Q40[19:0];

    // q30 sine coefficients
    localparam logic signed [31:0] S1 = 32'sd1073738173;
    localparam logic signed [31:0] S3 = -32'sd178937185;
    localparam logic signed [31:0] S5 = 32'sd8918811;
    localparam logic signed [31:0] S7 = -32'sd197171;

    // q30 cosine coefficients
    localparam logic signed [31:0] C0 = 32'sd1073741115;
    localparam logic signed [31:0] C2 = -32'sd536861517;
    localparam logic signed [31:0] C4 = 32'sd44734275;
    localparam logic signed [31:0] C6 = -32'sd1433735;
    localparam logic signed [31:0] C8 = 32'sd24846;

    // number of horner steps shared by both polynomials
    localparam int NSTEP = 4;

    // leading coefficient that seeds the horner chain
    function automatic logic signed [31:0] init_coef(input logic is_cos);
        return is_cos ? C8 : S7;
    endfunction

    // coefficient added after the product of each horner step
    function automatic logic signed [31:0] step_coef(input logic [1:0] step,
                                                     input logic is_cos);
        logic signed [31:0] c;
        unique case (step)
            2'd0:    c = is_cos ? C6 : S5;
            2'd1:    c = is_cos ? C4 : S3;
            2'd2:    c = is_cos ? C2 : S1;
            default: c = is_cos ? C0 : 32'sd0;
        endcase
        return c;
    endfunction

    // drop 30 fraction bits of a product, rounding half away from zero
    function automatic logic signed [31:0] round_q30(input logic signed [63:0] p);
        logic [63:0] s;
        s = p + (64'd1 << (PFRAC - 1)) - {63'd0, p[63]};
        return $signed(s[PFRAC+31:PFRAC]);
    endfunction

endpackage

// ----- rtl/core/sine_cosine_quadrant_poly_top.sv -----
// sine/cosine unit: quadrant reduction and shared horner polynomial pipeline
// throughput: one beat per cycle; each stage holds at most one 32x32 multiply
// or one round-and-add, so the multiplier stages set the clock
// a stalled output freezes the whole pipeline and stalls the input
// reset clears the stage valid bits only; datapath registers are not reset
module sine_cosine_quadrant_poly_top #(
    parameter int ANGLE_FRAC_BITS = 17,
    parameter int OUT_FRAC_BITS   = 30
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic signed [31:0] angle,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] value
);
    import scqp_pkg::*;

    localparam int KW    = 33 - ANGLE_FRAC_BITS;
    localparam int SH    = ANGLE_FRAC_BITS + 32;
    localparam int XS    = RFRAC - ANGLE_FRAC_BITS;
    localparam int DS    = PFRAC - OUT_FRAC_BITS;
    localparam int DS1   = (DS > 0) ? DS - 1 : 0;
    localparam int HALF  = (DS > 0) ? (1 << DS1) : 0;
    localparam int NSTG  = 17;
    localparam int LAST  = NSTG - 1;
    localparam logic signed [33:0] LIM  = 34'sd1 <<< OUT_FRAC_BITS;
    localparam logic signed [31:0] LIM32 = 32'sd1 <<< OUT_FRAC_BITS;

    // pipeline control
    logic [NSTG-1:0] vld_reg;
    logic            adv;

    assign adv       = !(vld_reg[LAST] && out_stall);
    assign in_stall  = vld_reg[LAST] && out_stall;
    assign out_valid = vld_reg[LAST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
        end
    end

    // stage 1: magnitude times 2/pi
    logic        a_neg;
    logic [31:0] a_mag;
    logic [63:0] s1_prod_next;
    logic [63:0] s1_prod_reg;
    logic signed [31:0] s1_a_reg;
    logic        s1_neg_reg;
    logic        s1_cos_reg;

    assign a_neg        = angle[31];
    assign a_mag        = a_neg ? 32'(-angle) : angle;
    assign s1_prod_next = {32'd0, a_mag} * {32'd0, TWO_OVER_PI_Q32};

    // stage 2: k rounded half away from zero, sign restored
    logic [63:0]          k_sum;
    logic [KW-2:0]        k_mag;
    logic signed [KW-1:0] s2_k_next;
    logic signed [KW-1:0] s2_k_reg;
    logic signed [31:0]   s2_a_reg;
    logic                 s2_cos_reg;

    assign k_sum     = s1_prod_reg + (64'd1 << (SH - 1));
    assign k_mag     = k_sum[63:SH];
    assign s2_k_next = s1_neg_reg ? -$signed({1'b0, k_mag}) : $signed({1'b0, k_mag});

    // stage 3: k times pi/2 in two partial products, angle moved to q40
    logic signed [KW+21:0] s3_phi_next;
    logic signed [KW+20:0] s3_plo_next;
    logic signed [63:0]    s3_x40_next;
    logic [1:0]            s3_q_next;
    logic signed [KW+21:0] s3_phi_reg;
    logic signed [KW+20:0] s3_plo_reg;
    logic signed [63:0]    s3_x40_reg;
    logic [1:0]            s3_q_reg;

    assign s3_phi_next = s2_k_reg * $signed({1'b0, HALF_PI_HI});
    assign s3_plo_next = s2_k_reg * $signed({1'b0, HALF_PI_LO});
    assign s3_x40_next = 64'(s2_a_reg) <<< XS;
    // quadrant of k, shifted by one for cosine
    assign s3_q_next   = s2_k_reg[1:0] + {1'b0, s2_cos_reg};

    // stage 4: reduced angle in q40
    logic signed [63:0] r40_full;
    logic signed [40:0] s4_r40_reg;
    logic [1:0]         s4_q_reg;

    assign r40_full = s3_x40_reg - (64'(s3_phi_reg) <<< 20) - 64'(s3_plo_reg);

    // stage 5: reduced angle rounded to q30
    logic [41:0]        r_sum;
    logic signed [31:0] s5_r_reg;
    logic [1:0]         s5_q_reg;

    assign r_sum = {s4_r40_reg[40], s4_r40_reg} + 42'd512 - {41'd0, s4_r40_reg[40]};

    // stages 6 and 7: r squared
    logic signed [63:0] s6_rr_reg;
    logic signed [31:0] s6_r_reg;
    logic [1:0]         s6_q_reg;
    logic signed [31:0] s7_r2_reg;
    logic signed [31:0] s7_r_reg;
    logic [1:0]         s7_q_reg;

    // horner steps: a product stage then a round-and-add stage each
    logic signed [63:0] pa_prod_reg [NSTEP];
    logic signed [31:0] pa_r_reg    [NSTEP];
    logic signed [31:0] pa_r2_reg   [NSTEP];
    logic [1:0]         pa_q_reg    [NSTEP];
    logic signed [31:0] pb_t_reg    [NSTEP];
    logic signed [31:0] pb_r_reg    [NSTEP];
    logic signed [31:0] pb_r2_reg   [NSTEP];
    logic [1:0]         pb_q_reg    [NSTEP];

    logic signed [31:0] h_t_in  [NSTEP];
    logic signed [31:0] h_r_in  [NSTEP];
    logic signed [31:0] h_r2_in [NSTEP];
    logic [1:0]         h_q_in  [NSTEP];
    logic signed [31:0] h_m_in  [NSTEP];
    logic signed [63:0] pa_prod_next [NSTEP];
    logic signed [31:0] pb_t_next    [NSTEP];

    // step inputs: first step seeds from the leading coefficient
    always_comb
    begin
        for (int i = 0; i < NSTEP; i++)
        begin
            if (i == 0)
            begin
                h_t_in[i]  = init_coef(s7_q_reg[0]);
                h_r_in[i]  = s7_r_reg;
                h_r2_in[i] = s7_r2_reg;
                h_q_in[i]  = s7_q_reg;
            end
            else
            begin
                h_t_in[i]  = pb_t_reg[i-1];
                h_r_in[i]  = pb_r_reg[i-1];
                h_r2_in[i] = pb_r2_reg[i-1];
                h_q_in[i]  = pb_q_reg[i-1];
            end
            // last sine step multiplies by r instead of r squared
            h_m_in[i]       = (i == NSTEP - 1 && !h_q_in[i][0]) ? h_r_in[i] : h_r2_in[i];
            pa_prod_next[i] = h_m_in[i] * h_t_in[i];
            pb_t_next[i]    = step_coef(2'(i), pa_q_reg[i][0]) + round_q30(pa_prod_reg[i]);
        end
    end

    // stage 16: sign from the quadrant
    logic signed [31:0] s15_v_reg;
    logic signed [31:0] s15_v_next;
    logic               s15_q1;

    assign s15_q1     = pb_q_reg[NSTEP-1][1];
    assign s15_v_next = s15_q1 ? -pb_t_reg[NSTEP-1] : pb_t_reg[NSTEP-1];

    // stage 17: round to the output format and saturate
    logic               rnd_neg;
    logic signed [33:0] v_sum;
    logic signed [33:0] v_shift;
    logic signed [33:0] v_sat;
    logic signed [31:0] out_value_reg;

    always_comb
    begin
        rnd_neg = (DS > 0) && s15_v_reg[31];
        v_sum   = 34'(s15_v_reg) + 34'(HALF) - 34'(rnd_neg);
        v_shift = v_sum >>> DS;
        priority if (v_shift > LIM)
        begin
            v_sat = LIM;
        end
        else if (v_shift < -LIM)
        begin
            v_sat = -LIM;
        end
        else
        begin
            v_sat = v_shift;
        end
    end

    assign value = out_value_reg;

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_prod_reg <= s1_prod_next;
            s1_a_reg    <= angle;
            s1_neg_reg  <= a_neg;
            s1_cos_reg  <= action;

            s2_k_reg    <= s2_k_next;
            s2_a_reg    <= s1_a_reg;
            s2_cos_reg  <= s1_cos_reg;

            s3_phi_reg  <= s3_phi_next;
            s3_plo_reg  <= s3_plo_next;
            s3_x40_reg  <= s3_x40_next;
            s3_q_reg    <= s3_q_next;

            s4_r40_reg  <= r40_full[40:0];
            s4_q_reg    <= s3_q_reg;

            s5_r_reg    <= $signed(r_sum[41:10]);
            s5_q_reg    <= s4_q_reg;

            s6_rr_reg   <= s5_r_reg * s5_r_reg;
            s6_r_reg    <= s5_r_reg;
            s6_q_reg    <= s5_q_reg;

            s7_r2_reg   <= round_q30(s6_rr_reg);
            s7_r_reg    <= s6_r_reg;
            s7_q_reg    <= s6_q_reg;

            for (int i = 0; i < NSTEP; i++)
            begin
                pa_prod_reg[i] <= pa_prod_next[i];
                pa_r_reg[i]    <= h_r_in[i];
                pa_r2_reg[i]   <= h_r2_in[i];
                pa_q_reg[i]    <= h_q_in[i];
                pb_t_reg[i]    <= pb_t_next[i];
                pb_r_reg[i]    <= pa_r_reg[i];
                pb_r2_reg[i]   <= pa_r2_reg[i];
                pb_q_reg[i]    <= pa_q_reg[i];
            end

            s15_v_reg     <= s15_v_next;
            out_value_reg <= v_sat[31:0];
        end
    end

    // checks
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> vld_reg[0])
        else $error("accepted beat did not enter the pipeline");

    a_freeze_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(vld_reg))
        else $error("pipeline moved while output stalled");

    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (value <= LIM32 && value >= -LIM32))
        else $error("result outside plus or minus one");

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for the sine/cosine quadrant polynomial unit
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ANGLE_FB = 17;
    localparam int OUT_FB = 30;
    localparam int RED_FB = 40;
    localparam int POLY_FB = 30;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DIR_ROWS = 24;
    localparam int PHASE_BEATS = 220;
    localparam int PRESSURE_BEATS = 70;
    localparam int HOLD_CYCLES = 90;
    localparam int DRAIN_CYCLES = 40;

    // request codes carried on the action port
    localparam logic ACT_SIN = 1'b0;
    localparam logic ACT_COS = 1'b1;

    // range reduction constants: 2/pi as unsigned q32, pi/2 as q40
    localparam longint unsigned INV_HALF_PI_Q32 = 64'd2734261102;
    localparam longint HALF_PI_Q40 = 64'sd1727108826179;

    // q30 polynomial coefficients
    localparam longint SIN_K1 = 64'sd1073738173;
    localparam longint SIN_K3 = -64'sd178937185;
    localparam longint SIN_K5 = 64'sd8918811;
    localparam longint SIN_K7 = -64'sd197171;
    localparam longint COS_K0 = 64'sd1073741115;
    localparam longint COS_K2 = -64'sd536861517;
    localparam longint COS_K4 = 64'sd44734275;
    localparam longint COS_K6 = -64'sd1433735;
    localparam longint COS_K8 = 64'sd24846;

    typedef struct packed {
        logic act;
        logic [31:0] ang;
        logic known;
        logic [31:0] val;
    } dir_row_t;

    typedef struct {
        logic act;
        logic signed [31:0] ang;
        logic signed [31:0] val;
    } pending_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic action;
    logic signed [31:0] angle;
    logic out_valid;
    logic out_stall;
    logic signed [31:0] value;

    pending_t expected_values [$];
    dir_row_t dir_rows [DIR_ROWS];

    int error_count = 0;
    int cycle_count = 0;
    int beats_sent = 0;
    int sin_beats = 0;
    int cos_beats = 0;
    int results_checked = 0;
    int input_stall_cycles = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_len = 0;

    sine_cosine_quadrant_poly_top #(
        .ANGLE_FRAC_BITS(ANGLE_FB),
        .OUT_FRAC_BITS(OUT_FB)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .angle(angle),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .value(value)
    );

    // clock, 8 ns period
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // signed shift right, rounding half away from zero
    function automatic longint round_shift(input longint v, input int s);
        logic neg;
        longint unsigned m;
        if (s == 0)
            return v;
        neg = v < 0;
        m = neg ? longint'(-v) : v;
        m = (m + (64'd1 << (s - 1))) >> s;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint fx_mul(input longint a, input longint b);
        return round_shift(a * b, POLY_FB);
    endfunction

    function automatic longint sine_series(input longint r);
        longint r2;
        longint t;
        r2 = fx_mul(r, r);
        t = SIN_K7;
        t = SIN_K5 + fx_mul(r2, t);
        t = SIN_K3 + fx_mul(r2, t);
        t = SIN_K1 + fx_mul(r2, t);
        return fx_mul(r, t);
    endfunction

    function automatic longint cosine_series(input longint r);
        longint r2;
        longint t;
        r2 = fx_mul(r, r);
        t = COS_K8;
        t = COS_K6 + fx_mul(r2, t);
        t = COS_K4 + fx_mul(r2, t);
        t = COS_K2 + fx_mul(r2, t);
        return COS_K0 + fx_mul(r2, t);
    endfunction

    // full result: quadrant reduction, series, sign pick and clamp
    function automatic logic signed [31:0] sincos_value(input logic act,
                                                         input logic signed [31:0] ang);
        longint a;
        longint k;
        longint r40;
        longint r;
        longint v;
        longint lim;
        longint unsigned mag;
        longint unsigned kmag;
        logic [1:0] quad;
        a = ang;
        mag = (a < 0) ? longint'(-a) : a;
        kmag = (mag * INV_HALF_PI_Q32 + (64'd1 << (ANGLE_FB + 31))) >> (ANGLE_FB + 32);
        k = (a < 0) ? -longint'(kmag) : longint'(kmag);
        r40 = a * (longint'(1) << (RED_FB - ANGLE_FB)) - k * HALF_PI_Q40;
        r = round_shift(r40, RED_FB - POLY_FB);
        quad = k[1:0];
        if (act == ACT_COS)
            quad = quad + 2'd1;
        case (quad)
            2'd0: v = sine_series(r);
            2'd1: v = cosine_series(r);
            2'd2: v = -sine_series(r);
            default: v = -cosine_series(r);
        endcase
        v = round_shift(v, POLY_FB - OUT_FB);
        lim = longint'(1) << OUT_FB;
        if (v > lim)
            v = lim;
        if (v < -lim)
            v = -lim;
        return v[31:0];
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= 30)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // offer one beat, with random idle cycles ahead of it; entered at a falling edge
    task automatic send_beat(input logic act, input logic signed [31:0] ang,
                             input logic use_given, input logic signed [31:0] given);
        pending_t p;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        angle <= ang;
        do
            @(posedge clk);
        while (in_stall);
        p.act = act;
        p.ang = ang;
        p.val = use_given ? given : sincos_value(act, ang);
        expected_values.push_back(p);
        beats_sent++;
        if (act == ACT_COS)
            cos_beats++;
        else
            sin_beats++;
        @(negedge clk);
    endtask

    // random angle: full range, small angles, quadrant edges, range ends
    task automatic send_random_beat();
        int pick;
        int m;
        logic signed [31:0] ang;
        pick = $urandom_range(99);
        m = int'($urandom_range(128)) - 64;
        if (pick < 30)
            ang = $urandom;
        else if (pick < 65)
            ang = int'($urandom_range(2 * (8 << ANGLE_FB))) - (8 << ANGLE_FB);
        else if (pick < 85)
            ang = (m * 1029437) / 10 + int'($urandom_range(64)) - 32;
        else if (pick < 92)
            ang = 32'sh7fffffff - int'($urandom_range(4095));
        else
            ang = 32'sh80000000 + int'($urandom_range(4095));
        send_beat(logic'($urandom_range(1)), ang, 1'b0, 32'sd0);
    endtask

    task automatic run_phase(input int send_idle, input int recv_stall, input int beats);
        idle_pct = send_idle;
        stall_pct = recv_stall;
        repeat (beats) send_random_beat();
    endtask

    // receiver: random stall, or a long counted hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_len > 0)
            begin
                out_stall <= 1'b1;
                for (int n = 0; n < hold_len; n++)
                    @(negedge clk);
                hold_len = 0;
                out_stall <= 1'b0;
            end
            else
                out_stall <= (stall_pct != 0 && $urandom_range(99) < stall_pct);
        end
    end

    // output check against the oldest expectation
    always @(posedge clk)
    begin
        pending_t p;
        if (rst_n)
        begin
            if (in_valid && in_stall)
                input_stall_cycles++;
            if (out_valid === 1'b1 && out_stall == 1'b0)
            begin
                if (expected_values.size() == 0)
                    report_mismatch($sformatf("unexpected result beat value=%0d", value));
                else
                begin
                    p = expected_values.pop_front();
                    results_checked++;
                    if (value !== p.val)
                        report_mismatch($sformatf("action=%0d angle=%0d value=%0d expected=%0d",
                                                  p.act, p.ang, value, p.val));
                end
            end
        end
    end

    // run length guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_values.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        // directed rows: zero, unit steps, range ends, quadrant edges, near half in k
        dir_rows = '{
            '{ACT_SIN, 32'sd0, 1'b1, 32'sd0},
            '{ACT_COS, 32'sd0, 1'b1, 32'sd1073741115},
            '{ACT_SIN, 32'sd1, 1'b0, 32'sd0},
            '{ACT_COS, -32'sd1, 1'b0, 32'sd0},
            '{ACT_SIN, 32'sh7fffffff, 1'b0, 32'sd0},
            '{ACT_COS, 32'sh7fffffff, 1'b0, 32'sd0},
            '{ACT_SIN, 32'sh80000000, 1'b0, 32'sd0},
            '{ACT_COS, 32'sh80000000, 1'b0, 32'sd0},
            '{ACT_SIN, 32'sd205887, 1'b0, 32'sd0},
            '{ACT_COS, 32'sd205887, 1'b0, 32'sd0},
            '{ACT_SIN, -32'sd205887, 1'b0, 32'sd0},
            '{ACT_COS, 32'sd411775, 1'b0, 32'sd0},
            '{ACT_SIN, -32'sd411775, 1'b0, 32'sd0},
            '{ACT_COS, 32'sd617662, 1'b0, 32'sd0},
            '{ACT_SIN, 32'sd823550, 1'b0, 32'sd0},
            '{ACT_COS, -32'sd823550, 1'b0, 32'sd0},
            '{ACT_SIN, 32'sd102943, 1'b0, 32'sd0},
            '{ACT_SIN, 32'sd102944, 1'b0, 32'sd0},
            '{ACT_COS, -32'sd102943, 1'b0, 32'sd0},
            '{ACT_COS, -32'sd102944, 1'b0, 32'sd0},
            '{ACT_SIN, 32'sd308831, 1'b0, 32'sd0},
            '{ACT_COS, 32'sd308832, 1'b0, 32'sd0},
            '{ACT_SIN, 32'sh55555555, 1'b0, 32'sd0},
            '{ACT_COS, 32'shaaaaaaaa, 1'b0, 32'sd0}
        };
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ACT_SIN;
        angle = 32'sd0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_beat(dir_rows[i].act, dir_rows[i].ang, dir_rows[i].known, dir_rows[i].val);

        run_phase(0, 0, PHASE_BEATS);
        run_phase(70, 0, PHASE_BEATS);
        run_phase(0, 70, PHASE_BEATS);
        run_phase(10, 10, PHASE_BEATS);

        // long receiver hold-off while beats keep coming, so the pipe backs up
        idle_pct = 0;
        stall_pct = 0;
        hold_len = HOLD_CYCLES;
        repeat (PRESSURE_BEATS) send_random_beat();

        in_valid <= 1'b0;
        stall_pct = 0;
        while (expected_values.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d beats (%0d sine, %0d cosine), %0d results checked",
                 beats_sent, sin_beats, cos_beats, results_checked);
        $display("input held off on %0d cycles, %0d mismatches", input_stall_cycles, error_count);
        if (error_count == 0 && expected_values.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
